FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the sensor receiver.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dht_pkg.sv
// Shared types and constants of the single-wire sensor receiver.
// Used by dht_cfg, dht_seq and dht11_sensor_receiver_top; no dependencies.
package dht_pkg;

  // Width of the configuration registers and of the config index.
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;

  // Number of data bits in one sensor frame.
  localparam int unsigned BitsPerRead = 40;
  localparam int unsigned BitIdxWidth = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CfgStartLow = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgRelease  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgTimeout  = 2'd2;

  // Register values after reset.
  localparam logic [CfgWidth-1:0] StartLowReset = 16'd20000;
  localparam logic [CfgWidth-1:0] ReleaseReset  = 16'd50;
  localparam logic [CfgWidth-1:0] TimeoutReset  = 16'd12000;

  // Stream payload widths.
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 24;

  // Read sequence phases.
  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_START_LOW = 7'b0000010,
    PH_RELEASE   = 7'b0000100,
    PH_RESP_LOW  = 7'b0001000,
    PH_RESP_HIGH = 7'b0010000,
    PH_BIT_LOW   = 7'b0100000,
    PH_BIT_HIGH  = 7'b1000000
  } phase_e;

  // Timing settings seen by the sequencer.
  typedef struct packed {
    logic [CfgWidth-1:0] start_low_ticks;
    logic [CfgWidth-1:0] release_ticks;
    logic [CfgWidth-1:0] timeout_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [7:0] humidity;
    logic [7:0] temperature;
    logic       read_ok;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

endpackage

FILE: hw/rtl/dht_cfg.sv
// Configuration register file of the sensor receiver: three timing registers.
// Depends on dht_pkg.
module dht_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dht_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [dht_pkg::CfgWidth-1:0]    cfg_data_i,
  output dht_pkg::cfg_t                   cfg_o
);
  import dht_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks <= StartLowReset;
      cfg_q.release_ticks   <= ReleaseReset;
      cfg_q.timeout_ticks   <= TimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStartLow: cfg_q.start_low_ticks <= cfg_data_i;
        CfgRelease:  cfg_q.release_ticks   <= cfg_data_i;
        CfgTimeout:  cfg_q.timeout_ticks   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/dht_seq.sv
// Read sequencer: phase state, tick counter, bit shifter and checksum check.
// Advances one sample tick per step; depends on dht_pkg.
module dht_seq #(
  parameter int unsigned TickBits = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             start_request_i,
  input  logic             line_level_i,
  input  dht_pkg::cfg_t    cfg_i,
  output dht_pkg::result_t res_o
);
  import dht_pkg::*;

  localparam int unsigned CmpBits = (TickBits > CfgWidth) ? TickBits : CfgWidth;
  localparam logic [TickBits-1:0] CntMax = '1;
  localparam logic [TickBits-1:0] OneTick = TickBits'(1);

  // Counter has reached a limit or saturated.
  function automatic logic count_full(logic [TickBits-1:0] t, logic [CfgWidth-1:0] lim);
    return (CmpBits'(t) >= CmpBits'(lim)) || (t == CntMax);
  endfunction

  // Saturating increment of the tick counter.
  function automatic logic [TickBits-1:0] sat_inc(logic [TickBits-1:0] t);
    return (t == CntMax) ? t : t + OneTick;
  endfunction

  phase_e                 phase_q, phase_d;
  logic [TickBits-1:0]    ticks_q, ticks_d;
  logic [TickBits-1:0]    low_q, low_d;
  logic [BitIdxWidth-1:0] idx_q, idx_d;
  logic [BitsPerRead-1:0] shift_q, shift_d;
  logic [7:0]             temp_q, temp_d;
  logic [7:0]             hum_q, hum_d;
  logic                   ok_q, ok_d;

  logic                   done;
  logic                   tm_en;
  phase_e                 tm_phase;
  logic [TickBits-1:0]    tm_ticks;
  logic [TickBits-1:0]    inc_t;
  logic                   expect_lvl;
  logic                   fail;
  logic                   finish;
  logic [7:0]             csum;

  // Next state for one sample tick.
  always_comb begin
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    low_d    = low_q;
    idx_d    = idx_q;
    shift_d  = shift_q;
    temp_d   = temp_q;
    hum_d    = hum_q;
    ok_d     = ok_q;
    done     = 1'b0;
    tm_en    = 1'b0;
    tm_phase = phase_q;
    tm_ticks = ticks_q;
    inc_t    = '0;
    expect_lvl = 1'b0;
    fail     = 1'b0;
    finish   = 1'b0;
    csum     = '0;

    // Untimed phases; a finished release hands over to response timing.
    case (phase_q)
      PH_IDLE: begin
        if (start_request_i) begin
          if (count_full(OneTick, cfg_i.start_low_ticks)) begin
            phase_d = PH_RELEASE;
            ticks_d = '0;
          end else begin
            phase_d = PH_START_LOW;
            ticks_d = OneTick;
          end
        end
      end
      PH_START_LOW: begin
        inc_t = sat_inc(ticks_q);
        if (count_full(inc_t, cfg_i.start_low_ticks)) begin
          phase_d = PH_RELEASE;
          ticks_d = '0;
        end else begin
          ticks_d = inc_t;
        end
      end
      PH_RELEASE: begin
        if (count_full(ticks_q, cfg_i.release_ticks)) begin
          tm_en    = 1'b1;
          tm_phase = PH_RESP_LOW;
          tm_ticks = '0;
        end else begin
          ticks_d = ticks_q + OneTick;
        end
      end
      PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
        tm_en = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // Timed phases: count at the expected level, close the phase on a flip.
    if (tm_en) begin
      expect_lvl = (tm_phase == PH_RESP_HIGH) || (tm_phase == PH_BIT_HIGH);
      if (line_level_i == expect_lvl) begin
        inc_t   = sat_inc(tm_ticks);
        phase_d = tm_phase;
        ticks_d = inc_t;
        fail    = count_full(inc_t, cfg_i.timeout_ticks);
      end else if (tm_ticks == '0) begin
        fail = 1'b1;
      end else begin
        phase_d = tm_phase;
        ticks_d = OneTick;
        case (tm_phase)
          PH_RESP_LOW: begin
            phase_d = PH_RESP_HIGH;
          end
          PH_RESP_HIGH: begin
            idx_d   = '0;
            shift_d = '0;
            phase_d = PH_BIT_LOW;
          end
          PH_BIT_LOW: begin
            low_d   = tm_ticks;
            phase_d = PH_BIT_HIGH;
          end
          PH_BIT_HIGH: begin
            shift_d = {shift_q[BitsPerRead-2:0], (tm_ticks > low_q)};
            idx_d   = idx_q + BitIdxWidth'(1);
            if (idx_d >= BitIdxWidth'(BitsPerRead)) begin
              finish = 1'b1;
            end else begin
              phase_d = PH_BIT_LOW;
            end
          end
          default: begin
            fail = 1'b1;
          end
        endcase
        if (!finish) begin
          fail = fail || count_full(OneTick, cfg_i.timeout_ticks);
        end
      end

      // Frame complete: bytes 0..3 must sum to byte 4.
      if (finish) begin
        csum = shift_d[39:32] + shift_d[31:24] + shift_d[23:16] + shift_d[15:8];
        if (csum == shift_d[7:0]) begin
          hum_d  = shift_d[39:32];
          temp_d = shift_d[23:16];
          ok_d   = 1'b1;
        end else begin
          ok_d = 1'b0;
        end
        phase_d = PH_IDLE;
        ticks_d = '0;
        done    = 1'b1;
      end

      if (fail) begin
        ok_d    = 1'b0;
        phase_d = PH_IDLE;
        ticks_d = '0;
        done    = 1'b1;
      end
    end
  end

  // State registers, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ticks_q <= '0;
      low_q   <= '0;
      idx_q   <= '0;
      shift_q <= '0;
      temp_q  <= '0;
      hum_q   <= '0;
      ok_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      low_q   <= low_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      temp_q  <= temp_d;
      hum_q   <= hum_d;
      ok_q    <= ok_d;
    end
  end

  // Result reflects the state after this tick.
  assign res_o.drive_low   = (phase_d == PH_START_LOW);
  assign res_o.busy_res    = (phase_d != PH_IDLE);
  assign res_o.done_res    = done;
  assign res_o.read_ok     = ok_d;
  assign res_o.temperature = temp_d;
  assign res_o.humidity    = hum_d;

endmodule

FILE: hw/rtl/dht11_sensor_receiver_top.sv
// Single-wire humidity/temperature sensor receiver, one input item per sample tick.
// An accepted item passes the input register, then the result register, where its
// result can be taken. Throughput: one item per cycle while the result side does not
// stall, set by the single-pass sequencer step between the two registers.
// Reset (rst_ni low, asynchronous): idle, no stored items, timing registers at
// defaults. Depends on dht_pkg, dht_cfg, dht_seq and assert_macros.svh.
`include "assert_macros.svh"

module dht11_sensor_receiver_top #(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: [0] start_request, [1] line_level, [7:2] zero
  input  logic [dht_pkg::InDataWidth-1:0]  s_axis_tdata,
  // Result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: [0] drive_low, [1] busy_res, [2] done_res, [3] read_ok,
  //        [11:4] temperature, [19:12] humidity, [23:20] zero
  output logic [dht_pkg::OutDataWidth-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dht_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [dht_pkg::CfgWidth-1:0]     cfg_data_i
);
  import dht_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic    in_valid_q;
  logic    in_req_q;
  logic    in_line_q;
  logic    out_valid_q;
  result_t out_q;
  logic    out_free;
  logic    advance;

  // Pipeline handshake: an item moves on when the result slot is free or drains.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q  <= s_axis_tdata[0];
      in_line_q <= s_axis_tdata[1];
    end
  end

  dht_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dht_seq #(
    .TickBits (TICK_COUNT_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .start_request_i (in_req_q),
    .line_level_i    (in_line_q),
    .cfg_i           (cfg),
    .res_o           (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.humidity, out_q.temperature, out_q.read_ok,
                          out_q.done_res, out_q.busy_res, out_q.drive_low};

  // A finished read is never reported as still busy.
  `ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, m_axis_tvalid && out_q.done_res, !out_q.busy_res, "done item reported busy")

  // The line is only driven low inside a read.
  `ASSERT_IMPL(a_drive_in_read, clk_i, rst_ni, m_axis_tvalid && out_q.drive_low, out_q.busy_res, "line driven low while idle")

  // An item held in the input register is not lost while the result side stalls.
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !out_free, in_valid_q, "input item dropped under stall")

endmodule

FILE: dv/dht11_sensor_receiver_checker.sv
// Checker for the single-wire sensor receiver: predicts one result item per input item.
// It watches the input, result and configuration channels and compares each result.
// Depends on dht_pkg for the field layout, phase codes, register indexes and defaults.
`timescale 1ns / 100ps

module dht11_sensor_receiver_checker
  import dht_pkg::*;
#(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  // tdata: [0] start_request, [1] line_level, [7:2] zero
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // tdata: [0] drive_low, [1] busy_res, [2] done_res, [3] read_ok,
  //        [11:4] temperature, [19:12] humidity, [23:20] zero
  input  logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgWidth-1:0]     cfg_data_i,
  output int unsigned             err_cnt_o,
  output int unsigned             pending_o,
  output logic                    seq_busy_o
);

  localparam logic [TICK_COUNT_BITS-1:0] CntMax = '1;

  // Timing settings as last written.
  logic [CfgWidth-1:0] start_low_q;
  logic [CfgWidth-1:0] release_q;
  logic [CfgWidth-1:0] timeout_q;

  // Sequencer state of the predictor.
  phase_e                     rd_phase;
  logic [TICK_COUNT_BITS-1:0] rd_ticks;
  logic [TICK_COUNT_BITS-1:0] rd_low_len;
  logic [BitIdxWidth-1:0]     rd_bit_idx;
  logic [BitsPerRead-1:0]     rd_frame;
  logic [7:0]                 rd_temp;
  logic [7:0]                 rd_hum;
  logic                       rd_ok;
  logic                       rd_done;

  result_t     expected_readings[$];
  int unsigned fail_cnt = 0;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    fail_cnt++;
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got_v, want_v);
  endtask

  // A count is full at its limit or when the counter saturates.
  function automatic logic count_full(input logic [TICK_COUNT_BITS-1:0] ticks,
                                      input logic [CfgWidth-1:0] limit);
    return (ticks >= limit) || (ticks == CntMax);
  endfunction

  task automatic abort_read();
    rd_ok    = 1'b0;
    rd_phase = PH_IDLE;
    rd_ticks = '0;
    rd_done  = 1'b1;
  endtask

  // Checksum is the 8-bit sum of the first four bytes.
  task automatic close_frame();
    logic [7:0] sum;
    sum = rd_frame[39:32] + rd_frame[31:24] + rd_frame[23:16] + rd_frame[15:8];
    if (sum == rd_frame[7:0]) begin
      rd_hum  = rd_frame[39:32];
      rd_temp = rd_frame[23:16];
      rd_ok   = 1'b1;
    end else begin
      rd_ok = 1'b0;
    end
    rd_phase = PH_IDLE;
    rd_ticks = '0;
    rd_done  = 1'b1;
  endtask

  // One tick of a timed phase. The flip tick ends a phase and opens the next one.
  task automatic time_phase(input logic line);
    logic                       want_lvl;
    logic [TICK_COUNT_BITS-1:0] len;
    want_lvl = (rd_phase == PH_RESP_HIGH) || (rd_phase == PH_BIT_HIGH);
    if (line == want_lvl) begin
      if (rd_ticks != CntMax) rd_ticks++;
      if (count_full(rd_ticks, timeout_q)) abort_read();
    end else if (rd_ticks == '0) begin
      // Line was not at the expected level when the phase began.
      abort_read();
    end else begin
      len = rd_ticks;
      case (rd_phase)
        PH_RESP_LOW: begin
          rd_phase = PH_RESP_HIGH;
        end
        PH_RESP_HIGH: begin
          rd_bit_idx = '0;
          rd_frame   = '0;
          rd_phase   = PH_BIT_LOW;
        end
        PH_BIT_LOW: begin
          rd_low_len = len;
          rd_phase   = PH_BIT_HIGH;
        end
        default: begin
          rd_frame = {rd_frame[BitsPerRead-2:0], len > rd_low_len};
          rd_bit_idx++;
          if (rd_bit_idx >= BitsPerRead) begin
            close_frame();
          end else begin
            rd_phase = PH_BIT_LOW;
          end
        end
      endcase
      if (rd_phase != PH_IDLE) begin
        rd_ticks = 1;
        if (count_full(rd_ticks, timeout_q)) abort_read();
      end
    end
  endtask

  // Advances the sequencer by one sample tick and forms the result item.
  task automatic advance_reader(input logic req, input logic line, output result_t res);
    rd_done = 1'b0;
    case (rd_phase)
      PH_START_LOW: begin
        if (rd_ticks != CntMax) rd_ticks++;
        if (count_full(rd_ticks, start_low_q)) begin
          rd_phase = PH_RELEASE;
          rd_ticks = '0;
        end
      end
      PH_RELEASE: begin
        if (count_full(rd_ticks, release_q)) begin
          rd_phase = PH_RESP_LOW;
          rd_ticks = '0;
          time_phase(line);
        end else begin
          rd_ticks++;
        end
      end
      PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
        time_phase(line);
      end
      default: begin
        // Idle; a request here is the first driven-low tick.
        rd_phase = PH_IDLE;
        if (req) begin
          rd_phase = PH_START_LOW;
          rd_ticks = 1;
          if (count_full(rd_ticks, start_low_q)) begin
            rd_phase = PH_RELEASE;
            rd_ticks = '0;
          end
        end
      end
    endcase
    res.drive_low   = (rd_phase == PH_START_LOW);
    res.busy_res    = (rd_phase != PH_IDLE);
    res.done_res    = rd_done;
    res.read_ok     = rd_ok;
    res.temperature = rd_temp;
    res.humidity    = rd_hum;
  endtask

  // Channel monitor: result first, then register writes, then the new input item.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      start_low_q = StartLowReset;
      release_q   = ReleaseReset;
      timeout_q   = TimeoutReset;
      rd_phase    = PH_IDLE;
      rd_ticks    = '0;
      rd_low_len  = '0;
      rd_bit_idx  = '0;
      rd_frame    = '0;
      rd_temp     = '0;
      rd_hum      = '0;
      rd_ok       = 1'b0;
      rd_done     = 1'b0;
      expected_readings.delete();
      pending_o   <= 0;
      seq_busy_o  <= 1'b0;
      err_cnt_o   <= fail_cnt;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result item", m_axis_tdata, 0);
        end else begin
          want = expected_readings.pop_front();
          if (got.drive_low != want.drive_low)
            report_mismatch("drive_low", got.drive_low, want.drive_low);
          if (got.busy_res != want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.done_res != want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
          if (got.read_ok != want.read_ok)
            report_mismatch("read_ok", got.read_ok, want.read_ok);
          if (got.temperature != want.temperature)
            report_mismatch("temperature", got.temperature, want.temperature);
          if (got.humidity != want.humidity)
            report_mismatch("humidity", got.humidity, want.humidity);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgStartLow: start_low_q = cfg_data_i;
          CfgRelease:  release_q   = cfg_data_i;
          CfgTimeout:  timeout_q   = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_reader(s_axis_tdata[0], s_axis_tdata[1], want);
        expected_readings.push_back(want);
      end
      pending_o  <= expected_readings.size();
      seq_busy_o <= (rd_phase != PH_IDLE);
      err_cnt_o  <= fail_cnt;
    end
  end

endmodule

FILE: dv/dht11_sensor_receiver_top_test.sv
// Top of the sensor receiver testbench: clock, reset, sensor waveforms and the verdict.
// Depends on dht_pkg, dht11_sensor_receiver_top and dht11_sensor_receiver_checker.
`timescale 1ns / 100ps

module dht11_sensor_receiver_top_test;
  import dht_pkg::*;

  localparam int unsigned TickBits     = 16;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems   = 90;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // tdata: [0] start_request, [1] line_level, [7:2] zero
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // tdata: [0] drive_low, [1] busy_res, [2] done_res, [3] read_ok,
  //        [11:4] temperature, [19:12] humidity, [23:20] zero
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [CfgWidth-1:0]     cfg_data_i = '0;

  int unsigned err_cnt;
  int unsigned pending;
  logic        seq_busy;

  int unsigned   src_idle_pct = 0;
  int unsigned   sink_stall_pct = 0;
  bit            hold_off = 1'b0;
  int unsigned   items_sent = 0;
  logic [CfgWidth-1:0] cur_start = StartLowReset;
  logic [CfgWidth-1:0] cur_release = ReleaseReset;
  logic [CfgWidth-1:0] cur_timeout = TimeoutReset;

  dht11_sensor_receiver_top #(
    .TICK_COUNT_BITS(TickBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  dht11_sensor_receiver_checker #(
    .TICK_COUNT_BITS(TickBits)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending),
    .seq_busy_o    (seq_busy)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no item moving anywhere.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic coin();
    return $urandom_range(1) == 1;
  endfunction

  function automatic logic [39:0] with_checksum(input logic [31:0] body);
    return {body, body[31:24] + body[23:16] + body[15:8] + body[7:0]};
  endfunction

  // Offers one sample tick, with random gaps, and waits until it is taken.
  task automatic send_tick(input logic req, input logic line);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataWidth-2){1'b0}}, line, req};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Holds the line at one level until the sequencer is idle again.
  task automatic flush_reader(input logic line);
    do send_tick(1'b0, line); while (seq_busy);
  endtask

  // Stops offering items and waits until every result is in and the block is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_timing(input logic [CfgWidth-1:0] start_low,
                            input logic [CfgWidth-1:0] release_len,
                            input logic [CfgWidth-1:0] timeout);
    settle();
    write_reg(CfgStartLow, start_low);
    write_reg(CfgRelease, release_len);
    write_reg(CfgTimeout, timeout);
    cfg_valid_i <= 1'b0;
    cur_start   = start_low;
    cur_release = release_len;
    cur_timeout = timeout;
  endtask

  // Request, then the driven-low and released ticks, up to where timing starts.
  task automatic request_read();
    int unsigned pre;
    pre = (cur_start > 1) ? cur_start - 1 : 0;
    send_tick(1'b1, coin());
    repeat (pre) send_tick(coin(), 1'b0);
    repeat (cur_release) send_tick(coin(), 1'b1);
  endtask

  // Sensor answer: response low/high, then n_bits of the frame, MSB first.
  // Requests during the read are random and must be ignored.
  task automatic sensor_read(input logic [39:0] frame, input int unsigned lo_max,
                             input int unsigned n_bits);
    int unsigned lo;
    int unsigned hi;
    request_read();
    repeat ($urandom_range(lo_max, 1)) send_tick(coin(), 1'b0);
    repeat ($urandom_range(lo_max, 1)) send_tick(coin(), 1'b1);
    for (int i = 39; i >= 40 - int'(n_bits); i--) begin
      lo = $urandom_range(lo_max, 1);
      hi = frame[i] ? lo + $urandom_range(2, 1) : $urandom_range(lo, 1);
      repeat (lo) send_tick(coin(), 1'b0);
      repeat (hi) send_tick(coin(), 1'b1);
    end
    // A low tick ends the last high phase; a cut frame then times out.
    flush_reader(1'b0);
  endtask

  // Request then the line held at one level: a stuck or missing sensor.
  task automatic start_and_hold(input logic line);
    request_read();
    flush_reader(line);
  endtask

  // Request followed by line noise.
  task automatic noisy_read();
    send_tick(1'b1, coin());
    repeat ($urandom_range(60)) send_tick(coin(), coin());
    flush_reader(coin());
  endtask

  task automatic random_phase(input int unsigned src_pct, input int unsigned sink_pct,
                              input bit with_hold);
    int unsigned stop_at;
    int unsigned pick;
    logic [39:0] frame;
    set_timing($urandom_range(4, 1), $urandom_range(3), $urandom_range(30, 8));
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    if (with_hold) hold_off = 1'b1;
    stop_at = items_sent + PhaseItems;
    while (items_sent < stop_at) begin
      pick  = $urandom_range(99);
      frame = with_checksum($urandom());
      // Some frames carry a wrong checksum.
      if ($urandom_range(99) < 15) frame[7:0] = frame[7:0] ^ 8'($urandom_range(255, 1));
      if (pick < 70) begin
        sensor_read(frame, ($urandom_range(7) == 0) ? 5 : 2, 40);
      end else if (pick < 85) begin
        sensor_read(frame, 2, $urandom_range(39));
      end else begin
        noisy_read();
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed reads with short timing.
    set_timing(16'd2, 16'd1, 16'd8);
    sensor_read(40'h0, 2, 40);
    sensor_read(with_checksum(32'hFFFF_FFFF), 3, 40);
    // Bad checksum: read fails, last good values are kept.
    sensor_read(with_checksum(32'h1234_5678) ^ 40'h1, 2, 40);
    // Line already high when response timing begins.
    start_and_hold(1'b1);
    // Response low never ends.
    start_and_hold(1'b0);
    // Frame cut off, so a bit phase times out.
    sensor_read(with_checksum(32'hA55A_3CC3), 2, 5);

    // Shortest settings: every timed phase fails at once.
    set_timing(16'd1, 16'd0, 16'd1);
    sensor_read(with_checksum(32'h0102_0304), 2, 40);
    set_timing(16'd0, 16'd0, 16'd0);
    start_and_hold(1'b0);
    start_and_hold(1'b1);
    noisy_read();

    // Random traffic under several idling patterns.
    random_phase(0, 0, 1'b1);
    random_phase(67, 0, 1'b0);
    random_phase(0, 67, 1'b1);
    random_phase(9, 9, 1'b0);

    settle();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
